// ----- hw/rtl/i2c_master_bit_sequencer_top_assert.svh -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Concurrent property wrappers for the sequencer top level.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CMBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2cmbs_pkg.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Types, codes and timing constants shared by the sequencer modules.
// ---------------------------------------------------------------------------
package i2cmbs_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_SP_C    = 4'd5,
    PH_SB_SET  = 4'd6,
    PH_SB_HIGH = 4'd7,
    PH_SB_LOW  = 4'd8,
    PH_RB_LOW  = 4'd9,
    PH_RB_HIGH = 4'd10,
    PH_AK_LOW  = 4'd11,
    PH_AK_HIGH = 4'd12,
    PH_WA_A    = 4'd13,
    PH_WA_B    = 4'd14,
    PH_WA_P    = 4'd15
  } phase_e;

  localparam int unsigned DelayW = 3;
  localparam int unsigned BitW   = 3;

  // hold counts minus one (ticks a pin setting stays)
  localparam logic [DelayW-1:0] Hold1 = 3'd0;
  localparam logic [DelayW-1:0] Hold2 = 3'd1;
  localparam logic [DelayW-1:0] Hold5 = 3'd4;
  localparam logic [DelayW-1:0] Hold6 = 3'd5;

  localparam logic [BitW-1:0] LastBit = 3'd7;
  localparam logic [7:0] AckLimitRst = 8'd250;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_sample;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_item_t;

  typedef struct packed {
    logic in_full;
    logic take;
    logic out_free;
  } stage_ctrl_t;

endpackage

// ----- hw/rtl/i2cmbs_intf.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer channels
// Valid/ready channels for tick commands and pin results.
// ---------------------------------------------------------------------------
interface i2cmbs_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic       sda_sample;

  modport source (output valid, command, tx_byte, ack_to_send, sda_sample, input ready);
  modport sink   (input valid, command, tx_byte, ack_to_send, sda_sample, output ready);
endinterface

interface i2cmbs_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_failed, output ready);
endinterface

// ----- hw/rtl/i2cmbs_in_stage.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer input stage
// Registers one tick item; refills in the same cycle the core takes it.
// ---------------------------------------------------------------------------
module i2cmbs_in_stage
  import i2cmbs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  i2cmbs_cmd_if.sink      cmd_i,
  input  stage_ctrl_t     ctrl_i,
  output logic            full_o,
  output cmd_item_t       item_o
);

  logic      full_q, full_d;
  cmd_item_t item_q;
  logic      load;

  assign cmd_i.ready = !full_q || ctrl_i.take;
  assign load        = cmd_i.valid && cmd_i.ready;
  assign full_d      = load || (full_q && !ctrl_i.take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{command:     cmd_i.command,
                  tx_byte:     cmd_i.tx_byte,
                  ack_to_send: cmd_i.ack_to_send,
                  sda_sample:  cmd_i.sda_sample};
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

// ----- hw/rtl/i2cmbs_core.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer core
// Phase machine and pin state; one tick advanced per transfer taken.
// ---------------------------------------------------------------------------
module i2cmbs_core
  import i2cmbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  stage_ctrl_t ctrl_i,
  input  cmd_item_t   item_i,
  output res_item_t   res_o
);

  phase_e            phase_q, phase_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        poll_q, poll_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              drv_q, drv_d;
  logic              ackc_q, ackc_d;
  logic              fail_q, fail_d;
  logic [7:0]        rx_q, rx_d;
  logic [7:0]        limit_q;
  logic              done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AckLimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      delay_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      poll_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      ackc_q  <= 1'b0;
      fail_q  <= 1'b0;
      rx_q    <= '0;
    end else if (ctrl_i.take) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      ackc_q  <= ackc_d;
      fail_q  <= fail_d;
      rx_q    <= rx_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    ackc_d  = ackc_q;
    fail_d  = fail_q;
    rx_d    = rx_q;
    done_d  = 1'b0;

    if (phase_q == PH_IDLE) begin
      unique case (cmd_e'(item_i.command))
        CMD_START: begin
          drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          phase_d = PH_ST_A; delay_d = Hold5;
        end
        CMD_STOP: begin
          drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          phase_d = PH_SP_A; delay_d = Hold1;
        end
        CMD_SEND: begin
          shift_d = item_i.tx_byte; bit_d = '0;
          drv_d = 1'b1; scl_d = 1'b0; sda_d = item_i.tx_byte[7];
          phase_d = PH_SB_SET; delay_d = Hold1;
        end
        CMD_READ: begin
          drv_d = 1'b0; sda_d = 1'b1; scl_d = 1'b0;
          bit_d = '0; shift_d = '0; ackc_d = item_i.ack_to_send;
          phase_d = PH_RB_LOW; delay_d = Hold2;
        end
        CMD_WACK: begin
          drv_d = 1'b0; sda_d = 1'b1; poll_d = '0; fail_d = 1'b0;
          phase_d = PH_WA_A; delay_d = Hold1;
        end
        default: ;
      endcase
    end else if (delay_q != '0) begin
      delay_d = delay_q - 1'b1;
    end else begin
      unique case (phase_q)
        PH_ST_A: begin sda_d = 1'b0; phase_d = PH_ST_B; delay_d = Hold6; end
        PH_ST_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
        PH_SP_A: begin scl_d = 1'b1; phase_d = PH_SP_B; delay_d = Hold6; end
        PH_SP_B: begin sda_d = 1'b1; phase_d = PH_SP_C; delay_d = Hold6; end
        PH_SB_SET: begin scl_d = 1'b1; phase_d = PH_SB_HIGH; delay_d = Hold2; end
        PH_SB_HIGH: begin scl_d = 1'b0; phase_d = PH_SB_LOW; delay_d = Hold2; end
        PH_SB_LOW: begin
          if (bit_q == LastBit) begin
            phase_d = PH_IDLE; done_d = 1'b1;
          end else begin
            bit_d   = bit_q + 1'b1;
            shift_d = {shift_q[6:0], 1'b0};
            sda_d   = shift_q[6];
            phase_d = PH_SB_SET; delay_d = Hold1;
          end
        end
        PH_RB_LOW: begin
          // sample on the rising SCL tick
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], item_i.sda_sample};
          phase_d = PH_RB_HIGH; delay_d = Hold1;
        end
        PH_RB_HIGH: begin
          scl_d = 1'b0;
          if (bit_q == LastBit) begin
            drv_d = 1'b1; sda_d = !ackc_q;
            phase_d = PH_AK_LOW; delay_d = Hold2;
          end else begin
            bit_d = bit_q + 1'b1;
            phase_d = PH_RB_LOW; delay_d = Hold2;
          end
        end
        PH_AK_LOW: begin scl_d = 1'b1; phase_d = PH_AK_HIGH; delay_d = Hold5; end
        PH_AK_HIGH: begin
          scl_d = 1'b0; rx_d = shift_q; phase_d = PH_IDLE; done_d = 1'b1;
        end
        PH_WA_A: begin scl_d = 1'b1; phase_d = PH_WA_B; delay_d = Hold1; end
        PH_WA_B, PH_WA_P: begin
          if (!item_i.sda_sample) begin
            scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
          end else if (poll_q >= limit_q) begin
            // timeout: flag it and fall into the stop sequence
            fail_d = 1'b1;
            drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
            phase_d = PH_SP_A; delay_d = Hold1;
          end else begin
            poll_d = poll_q + 1'b1;
            phase_d = PH_WA_P; delay_d = Hold1;
          end
        end
        default: begin phase_d = PH_IDLE; delay_d = '0; done_d = 1'b1; end
      endcase
    end
  end

  assign res_o = '{scl_level:  scl_d,
                   sda_level:  sda_d,
                   sda_drive:  drv_d,
                   busy_res:   (phase_d != PH_IDLE),
                   done_res:   done_d,
                   rx_byte:    rx_d,
                   ack_failed: fail_d};

endmodule

// ----- hw/rtl/i2cmbs_out_stage.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer output stage
// Result register that holds a pin result until the sink takes it.
// ---------------------------------------------------------------------------
module i2cmbs_out_stage
  import i2cmbs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  stage_ctrl_t  ctrl_i,
  input  res_item_t    res_i,
  output logic         free_o,
  i2cmbs_res_if.source res_o
);

  logic      valid_q, valid_d;
  res_item_t res_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = ctrl_i.take || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.scl_level  = res_q.scl_level;
  assign res_o.sda_level  = res_q.sda_level;
  assign res_o.sda_drive  = res_q.sda_drive;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.rx_byte    = res_q.rx_byte;
  assign res_o.ack_failed = res_q.ack_failed;

endmodule

// ----- hw/rtl/i2c_master_bit_sequencer_top.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer top level
// One input transfer per bus tick; drives SCL/SDA and reports status.
// ---------------------------------------------------------------------------
//  channel  | dir | modport | carries
//  cmd_i    | in  | sink    | command, tx_byte, ack_to_send, sda_sample
//  res_o    | out | source  | scl/sda levels, sda_drive, busy, done, rx_byte, ack_failed
//  cfg      | in  | we/data | ack_timeout_limit
//
// One tick per clock cycle; a tick transfer is taken every cycle while the
// result side keeps up. A tick passes through the input register, then the phase
// machine updates and loads the result register. A stalled result holds the
// tick in the input register and backs up cmd_i. Reset releases to idle with
// SCL, SDA high and driven; limit resets to 250.
module i2c_master_bit_sequencer_top
  import i2cmbs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  i2cmbs_cmd_if.sink   cmd_i,
  i2cmbs_res_if.source res_o
);

  `include "i2c_master_bit_sequencer_top_assert.svh"

  stage_ctrl_t ctrl;
  cmd_item_t   item;
  res_item_t   res_next;
  logic        in_full;
  logic        out_free;

  assign ctrl.in_full  = in_full;
  assign ctrl.out_free = out_free;
  assign ctrl.take     = in_full && out_free;

  i2cmbs_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .ctrl_i (ctrl),
    .full_o (in_full),
    .item_o (item)
  );

  i2cmbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .item_i      (item),
    .res_o       (res_next)
  );

  i2cmbs_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .res_i  (res_next),
    .free_o (out_free),
    .res_o  (res_o)
  );

  `I2CMBS_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, res_o.valid,
                     !(res_o.done_res && res_o.busy_res), "done while still busy")
  `I2CMBS_ASSERT_NOW(a_released_high, clk_i, rst_ni, res_o.valid,
                     res_o.sda_drive || res_o.sda_level, "released SDA not high")
  `I2CMBS_ASSERT_NEXT(a_take_gives_result, clk_i, rst_ni, ctrl.take,
                      res_o.valid, "taken tick produced no result")

endmodule
